FILE: rtl/core/button_debounce_click_detector_defines.svh
// assertion macros shared by the button scanner rtl
// expects clk and rst in the scope of each use
`ifndef BUTTON_DEBOUNCE_CLICK_DETECTOR_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_DETECTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BDCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BDCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bdcd_pkg.sv
// types and constants for the button scanner
// no dependencies
package bdcd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_ACCEPTED = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_B0       = 3'd1,
    EV_B1_SHORT = 3'd2,
    EV_B2_CLICK = 3'd3,
    EV_B1_LONG  = 3'd4,
    EV_B2_DBL   = 3'd5
  } event_t;

  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned TICK_WIDTH = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_CLICK   = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOUBLE_CLICK = 2'd3;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET     = 16'd100;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET   = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] HOLD_CLICK_RESET   = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] DOUBLE_CLICK_RESET = 16'd200;

endpackage

FILE: rtl/core/button_debounce_click_detector.sv
// an accepted item passes through the input register, then the result register, which
// gives its event code; throughput: one item per cycle while out_stall is low
// the scan state updates once per item as it moves from input to result register
// reset: synchronous, clears all button phases, start times and the pending click,
// loads the timing registers with their defaults and empties both stages
// depends on bdcd_pkg and button_debounce_click_detector_defines.svh
`include "button_debounce_click_detector_defines.svh"

module button_debounce_click_detector
  import bdcd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  // poll items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [TICK_WIDTH-1:0]      tick_ms,
  input  logic                       button0_level,
  input  logic                       button1_level,
  input  logic                       button2_level,
  // results
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 event_code
);

  // timing registers
  logic [CFG_WIDTH-1:0] debounce_ms;
  logic [CFG_WIDTH-1:0] long_press_ms;
  logic [CFG_WIDTH-1:0] hold_click_ms;
  logic [CFG_WIDTH-1:0] double_click_ms;

  // input stage
  logic                  s1_valid;
  logic [TICK_WIDTH-1:0] s1_tick;
  logic                  s1_press0;
  logic                  s1_press1;
  logic                  s1_press2;

  // scan state
  phase_t                b0_phase, b0_phase_next;
  logic [TICK_WIDTH-1:0] b0_start, b0_start_next;
  phase_t                b1_phase, b1_phase_next;
  logic [TICK_WIDTH-1:0] b1_start, b1_start_next;
  phase_t                b2_phase, b2_phase_next;
  logic [TICK_WIDTH-1:0] b2_start, b2_start_next;
  logic                  b2_pending, b2_pending_next;
  logic [TICK_WIDTH-1:0] b2_last_release, b2_last_release_next;

  // result stage
  event_t result_event;
  event_t event_next;
  event_t ev0;

  logic res_free;
  logic s1_advance;
  logic s1_load;

  logic [TICK_WIDTH-1:0] el0;
  logic [TICK_WIDTH-1:0] el1;
  logic [TICK_WIDTH-1:0] el2;
  logic [TICK_WIDTH-1:0] el2_gap;

  assign res_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && res_free;
  assign in_stall   = s1_valid && !res_free;
  assign s1_load    = in_valid && !in_stall;

  // wrapping elapsed times
  assign el0     = s1_tick - b0_start;
  assign el1     = s1_tick - b1_start;
  assign el2     = s1_tick - b2_start;
  assign el2_gap = s1_tick - b2_last_release;

  assign event_code = result_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DEBOUNCE_RESET;
      long_press_ms   <= LONG_PRESS_RESET;
      hold_click_ms   <= HOLD_CLICK_RESET;
      double_click_ms <= DOUBLE_CLICK_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_DEBOUNCE:     debounce_ms     <= cfg_data;
        REG_LONG_PRESS:   long_press_ms   <= cfg_data;
        REG_HOLD_CLICK:   hold_click_ms   <= cfg_data;
        REG_DOUBLE_CLICK: double_click_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // levels are active low
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_tick   <= tick_ms;
      s1_press0 <= !button0_level;
      s1_press1 <= !button1_level;
      s1_press2 <= !button2_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_phase        <= PH_IDLE;
      b0_start        <= '0;
      b1_phase        <= PH_IDLE;
      b1_start        <= '0;
      b2_phase        <= PH_IDLE;
      b2_start        <= '0;
      b2_pending      <= 1'b0;
      b2_last_release <= '0;
    end else if (s1_advance) begin
      b0_phase        <= b0_phase_next;
      b0_start        <= b0_start_next;
      b1_phase        <= b1_phase_next;
      b1_start        <= b1_start_next;
      b2_phase        <= b2_phase_next;
      b2_start        <= b2_start_next;
      b2_pending      <= b2_pending_next;
      b2_last_release <= b2_last_release_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result_event <= event_next;
    end
  end

  // buttons scanned in order, first event ends the poll
  always_comb begin
    b0_phase_next        = b0_phase;
    b0_start_next        = b0_start;
    b1_phase_next        = b1_phase;
    b1_start_next        = b1_start;
    b2_phase_next        = b2_phase;
    b2_start_next        = b2_start;
    b2_pending_next      = b2_pending;
    b2_last_release_next = b2_last_release;
    ev0                  = EV_NONE;
    event_next           = EV_NONE;

    // button 0: debounce, report on release
    if (s1_press0) begin
      case (b0_phase)
        PH_IDLE: begin
          b0_phase_next = PH_PRESSED;
          b0_start_next = s1_tick;
        end
        PH_PRESSED: begin
          if (el0 > {16'd0, debounce_ms}) b0_phase_next = PH_ACCEPTED;
        end
        default: ;
      endcase
    end else if (b0_phase == PH_ACCEPTED) begin
      b0_phase_next = PH_IDLE;
      ev0           = EV_B0;
    end
    event_next = ev0;

    // button 1: short on release, long once hold time passes
    if (ev0 == EV_NONE) begin
      if (s1_press1) begin
        case (b1_phase)
          PH_IDLE: begin
            b1_phase_next = PH_PRESSED;
            b1_start_next = s1_tick;
          end
          PH_PRESSED: begin
            if (el1 > {16'd0, debounce_ms}) begin
              b1_phase_next = PH_ACCEPTED;
              b1_start_next = s1_tick;
            end
          end
          PH_ACCEPTED: begin
            if (el1 > {16'd0, long_press_ms}) begin
              b1_phase_next = PH_LONG;
              event_next    = EV_B1_LONG;
            end
          end
          default: ;
        endcase
      end else if (b1_phase == PH_ACCEPTED) begin
        b1_phase_next = PH_IDLE;
        event_next    = EV_B1_SHORT;
      end else if (b1_phase == PH_LONG) begin
        b1_phase_next = PH_IDLE;
      end
    end

    // button 2: click after long hold, double click on two short presses
    if (ev0 == EV_NONE && event_next == EV_NONE) begin
      if (s1_press2) begin
        case (b2_phase)
          PH_IDLE: begin
            b2_phase_next = PH_PRESSED;
            b2_start_next = s1_tick;
          end
          PH_PRESSED: begin
            if (el2 > {16'd0, hold_click_ms}) b2_phase_next = PH_ACCEPTED;
          end
          default: ;
        endcase
      end else if (b2_phase == PH_ACCEPTED) begin
        b2_phase_next = PH_IDLE;
        event_next    = EV_B2_CLICK;
      end else if (b2_phase != PH_IDLE) begin
        b2_phase_next        = PH_IDLE;
        b2_last_release_next = s1_tick;
        if (b2_pending && (el2_gap < {16'd0, double_click_ms})) begin
          b2_pending_next = 1'b0;
          event_next      = EV_B2_DBL;
        end else begin
          b2_pending_next = 1'b1;
        end
      end
    end
  end

  `BDCD_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid, "stall with empty input stage")
  `BDCD_ASSERT_NEXT(a_item_reaches_result, s1_advance, out_valid, "item lost before result")
  `BDCD_ASSERT_NEXT(a_b0_event_idles, s1_advance && ev0 == EV_B0,
                    b0_phase == PH_IDLE, "button 0 not idle after its event")
  `BDCD_ASSERT_NEXT(a_b0_event_blocks_rest, s1_advance && ev0 != EV_NONE,
                    $stable(b1_phase) && $stable(b2_phase) && $stable(b2_pending),
                    "later buttons moved in a poll ended by button 0")
  `BDCD_ASSERT_NEXT(a_double_clears_pending, s1_advance && event_next == EV_B2_DBL,
                    !b2_pending && b2_phase == PH_IDLE, "double click left a pending click")

endmodule

FILE: tb/bdcd_event_checker.sv
// event checker for the button scanner: predicts one event code per accepted poll item
// and compares every accepted result with the oldest prediction
// depends on bdcd_pkg
module bdcd_event_checker
  import bdcd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [TICK_WIDTH-1:0]      tick_ms,
  input  logic                       button0_level,
  input  logic                       button1_level,
  input  logic                       button2_level,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [2:0]                 event_code,
  output int                         outstanding,
  output int                         fail_count
);

  logic [CFG_WIDTH-1:0]  deb_ms, long_ms, hold_ms, dbl_ms;
  phase_t                key0_ph, key1_ph, key2_ph;
  logic [TICK_WIDTH-1:0] key0_t0, key1_t0, key2_t0, tap_time;
  logic [1:0]            tap_count;
  event_t                pending_events[$];

  // one poll: buttons in order 0, 1, 2, the first event ends the poll
  function automatic event_t scan_poll(input logic [TICK_WIDTH-1:0] now,
                                       input logic [2:0] lvl);
    logic [TICK_WIDTH-1:0] held0, held1, held2, since_tap;
    event_t ev;
    held0 = now - key0_t0;
    held1 = now - key1_t0;
    held2 = now - key2_t0;
    since_tap = now - tap_time;
    ev = EV_NONE;
    if (!lvl[0]) begin
      if (key0_ph == PH_IDLE) begin
        key0_ph = PH_PRESSED;
        key0_t0 = now;
      end else if (key0_ph == PH_PRESSED && held0 > deb_ms) begin
        key0_ph = PH_ACCEPTED;
      end
    end else if (key0_ph == PH_ACCEPTED) begin
      key0_ph = PH_IDLE;
      ev = EV_B0;
    end
    if (ev == EV_NONE) begin
      if (!lvl[1]) begin
        if (key1_ph == PH_IDLE) begin
          key1_ph = PH_PRESSED;
          key1_t0 = now;
        end else if (key1_ph == PH_PRESSED) begin
          // hold time counts from the moment the press is accepted
          if (held1 > deb_ms) begin
            key1_ph = PH_ACCEPTED;
            key1_t0 = now;
          end
        end else if (key1_ph == PH_ACCEPTED) begin
          if (held1 > long_ms) begin
            key1_ph = PH_LONG;
            ev = EV_B1_LONG;
          end
        end
      end else if (key1_ph == PH_ACCEPTED) begin
        key1_ph = PH_IDLE;
        ev = EV_B1_SHORT;
      end else if (key1_ph == PH_LONG) begin
        key1_ph = PH_IDLE;
      end
    end
    if (ev == EV_NONE) begin
      if (!lvl[2]) begin
        if (key2_ph == PH_IDLE) begin
          key2_ph = PH_PRESSED;
          key2_t0 = now;
        end else if (key2_ph == PH_PRESSED && held2 > hold_ms) begin
          key2_ph = PH_ACCEPTED;
        end
      end else if (key2_ph == PH_ACCEPTED) begin
        key2_ph = PH_IDLE;
        ev = EV_B2_CLICK;
      end else if (key2_ph != PH_IDLE) begin
        // short release: second tap close enough is a double, else a new first tap
        key2_ph = PH_IDLE;
        if (tap_count == 2'd1 && since_tap < dbl_ms) begin
          tap_count = 2'd0;
          ev = EV_B2_DBL;
        end else begin
          tap_count = 2'd1;
        end
        tap_time = now;
      end
    end
    return ev;
  endfunction

  always @(posedge clk) begin
    event_t want;
    if (rst) begin
      deb_ms = DEBOUNCE_RESET;
      long_ms = LONG_PRESS_RESET;
      hold_ms = HOLD_CLICK_RESET;
      dbl_ms = DOUBLE_CLICK_RESET;
      key0_ph = PH_IDLE;
      key1_ph = PH_IDLE;
      key2_ph = PH_IDLE;
      key0_t0 = '0;
      key1_t0 = '0;
      key2_t0 = '0;
      tap_time = '0;
      tap_count = 2'd0;
      pending_events.delete();
      fail_count = 0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_DEBOUNCE:     deb_ms = cfg_data;
          REG_LONG_PRESS:   long_ms = cfg_data;
          REG_HOLD_CLICK:   hold_ms = cfg_data;
          REG_DOUBLE_CLICK: dbl_ms = cfg_data;
          default: ;
        endcase
      end
      // compare before queueing so a result never matches an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: event_code %0d arrived with no item pending", $time, event_code);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          if (event_code !== want) begin
            $display("%0t: event_code expected %0d (%s) actual %0d",
                     $time, want, want.name(), event_code);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        pending_events.push_back(scan_poll(tick_ms,
                                           {button2_level, button1_level, button0_level}));
    end
    outstanding <= pending_events.size();
  end

endmodule

FILE: tb/tb_top.sv
// top of the button scanner testbench: clock, reset, poll and timing stimulus
// depends on bdcd_pkg, button_debounce_click_detector and bdcd_event_checker
module tb_top;
  import bdcd_pkg::*;

  localparam logic [2:0] ALL_UP  = 3'b111;
  localparam logic [2:0] B0_DOWN = 3'b110;
  localparam logic [2:0] B1_DOWN = 3'b101;
  localparam logic [2:0] B2_DOWN = 3'b011;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write_en = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]       cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [TICK_WIDTH-1:0]      tick_ms = '0;
  logic                       button0_level = 1'b1;
  logic                       button1_level = 1'b1;
  logic                       button2_level = 1'b1;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [2:0]                 event_code;
  int                         outstanding;
  int                         fail_count;

  // stimulus state
  logic [TICK_WIDTH-1:0] now_ms;
  logic [TICK_WIDTH-1:0] span;
  logic [CFG_WIDTH-1:0]  cur_deb, cur_lp, cur_hc, cur_dbl;
  bit                    steady = 1'b0;
  int                    sent = 0;

  always #6 clk = ~clk;

  button_debounce_click_detector u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .tick_ms       (tick_ms),
    .button0_level (button0_level),
    .button1_level (button1_level),
    .button2_level (button2_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_code    (event_code)
  );

  bdcd_event_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .tick_ms       (tick_ms),
    .button0_level (button0_level),
    .button1_level (button1_level),
    .button2_level (button2_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_code    (event_code),
    .outstanding   (outstanding),
    .fail_count    (fail_count)
  );

  // offer one item and hold it until taken
  task automatic poll(input logic [TICK_WIDTH-1:0] t, input logic [2:0] lvl);
    int gap;
    gap = 0;
    if (!steady) begin
      if ($urandom_range(0, 9) == 0)
        gap = $urandom_range(5, 25);
      else if ($urandom_range(0, 2) == 0)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick_ms <= t;
    button0_level <= lvl[0];
    button1_level <= lvl[1];
    button2_level <= lvl[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if ($urandom_range(0, 29) == 0)
      steady = !steady;
  endtask

  // stop offering and let every predicted event come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timing(input logic [CFG_WIDTH-1:0] deb, lp, hc, dc);
    drain();
    cfg_write_en <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_data <= lp;
    @(posedge clk);
    cfg_index <= REG_HOLD_CLICK;
    cfg_data <= hc;
    @(posedge clk);
    cfg_index <= REG_DOUBLE_CLICK;
    cfg_data <= dc;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_deb = deb;
    cur_lp = lp;
    cur_hc = hc;
    cur_dbl = dc;
  endtask

  // press some buttons for a few polls, then let go; tick steps sized to the timing
  task automatic gesture();
    logic [2:0] held, lvl;
    int presses, releases, pick;
    held = 3'($urandom_range(1, 7));
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2: span = cur_dbl / 2 + 1;
        3, 4:    span = cur_deb / 2 + 2;
        5, 6:    span = (cur_lp + cur_hc) / 4 + 4;
        default: span = 32'hffff_ffff;
      endcase
    end
    presses = $urandom_range(1, 9);
    releases = $urandom_range(1, 3);
    for (int i = 0; i < presses; i++) begin
      lvl = ~held;
      if ($urandom_range(0, 9) == 0) begin
        // a bounce on one pin
        pick = $urandom_range(0, 2);
        lvl[pick] = ~lvl[pick];
      end
      now_ms = now_ms + $urandom_range(0, span);
      poll(now_ms, lvl);
    end
    for (int i = 0; i < releases; i++) begin
      now_ms = now_ms + $urandom_range(0, span);
      poll(now_ms, ALL_UP);
    end
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = sent + count;
    now_ms = $urandom;
    span = cur_dbl / 2 + 1;
    while (sent < goal) begin
      if ($urandom_range(0, 99) < 85) begin
        gesture();
      end else begin
        now_ms = now_ms + $urandom_range(0, span);
        poll(now_ms, 3'($urandom));
      end
    end
  endtask

  // receiver: short random stalls, and a long hold-off now and then so the block fills up
  initial begin : receiver
    int run, since_hold;
    since_hold = 300;
    wait (!rst);
    forever begin
      if (since_hold >= 700) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        since_hold = 0;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (run) @(posedge clk);
        since_hold += run;
      end
    end
  end

  initial begin : watchdog
    #(12 * 300000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    cur_deb = DEBOUNCE_RESET;
    cur_lp = LONG_PRESS_RESET;
    cur_hc = HOLD_CLICK_RESET;
    cur_dbl = DOUBLE_CLICK_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, at reset timing
    poll(32'd1000, B0_DOWN);
    poll(32'd1101, B0_DOWN);
    poll(32'd1150, ALL_UP);
    // bounce on button 0 keeps the old start time
    poll(32'd2000, B0_DOWN);
    poll(32'd2010, ALL_UP);
    poll(32'd2200, B0_DOWN);
    poll(32'd2210, ALL_UP);
    poll(32'd3000, B1_DOWN);
    poll(32'd3101, B1_DOWN);
    poll(32'd3200, ALL_UP);
    // long press on button 1, silent release
    poll(32'd4000, B1_DOWN);
    poll(32'd4101, B1_DOWN);
    poll(32'd5102, B1_DOWN);
    poll(32'd5200, ALL_UP);
    poll(32'd6000, B2_DOWN);
    poll(32'd7001, B2_DOWN);
    poll(32'd7100, ALL_UP);
    // double tap, then a second tap that comes too late
    poll(32'd8000, B2_DOWN);
    poll(32'd8050, ALL_UP);
    poll(32'd8100, B2_DOWN);
    poll(32'd8150, ALL_UP);
    poll(32'd9000, B2_DOWN);
    poll(32'd9010, ALL_UP);
    poll(32'd9500, B2_DOWN);
    poll(32'd9600, ALL_UP);
    // debounce across the tick wrap
    poll(32'hffff_fff0, B0_DOWN);
    poll(32'h0000_0080, B0_DOWN);
    poll(32'h0000_0090, ALL_UP);

    set_timing(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(80);
    set_timing(16'd6, 16'd25, 16'd20, 16'd15);
    run_random(80);
    set_timing(DEBOUNCE_RESET, LONG_PRESS_RESET, HOLD_CLICK_RESET, DOUBLE_CLICK_RESET);
    run_random(80);
    set_timing(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    run_random(80);
    set_timing(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
               16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
    run_random(80);

    drain();
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
